// File: rtl/pair_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_pkg
// Shared widths, operation and status codes, and the command/status bundles
// passed between the controller and the datapath of the positional store.
// ----------------------------------------------------------------------------
package pair_pkg;

	localparam int FUNC_W  = 2;
	localparam int POS_W   = 16;
	localparam int WORD_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 9;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

	localparam logic [COUNT_W-1:0] CAP_RESET = 9'd256;

	typedef struct packed {
		logic load_op;
		logic decode;
		logic shift_rd;
		logic shift_wr;
		logic write_word;
		logic read_issue;
		logic count_inc;
		logic count_dec;
		logic result_load;
	} pair_cmd_t;

	typedef struct packed {
		logic op_ok;
		logic is_insert;
		logic is_read;
		logic ptr_done;
		logic out_busy;
	} pair_stat_t;

endpackage

// File: rtl/positional_array_insert_remove_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_insert_remove_core
// Ordered store of signed 32-bit words with insert, remove and read at a
// position, a running entry count and a programmable capacity limit.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. Entries live in a single-port-write,
// single-port-read memory with a registered read, so a shift step reads one
// entry and then writes it one place over. Insert shifts the entries from its
// index up and writes the new word, remove shifts those above its index down,
// read issues one memory read, and a rejected operation goes straight to the
// result register; the store returns to idle before accepting the next
// transaction. A pending result may sit stalled at the output while the next
// transaction is accepted and processed. The entry memory needs no clearing
// after reset. Capacity register writes take effect at the next transaction.
module positional_array_insert_remove_core import pair_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [POS_W-1:0]  position,
	input  logic signed [WORD_W-1:0] data_word,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [STAT_W-1:0]        status,
	output logic [COUNT_W-1:0]       entry_count,
	output logic signed [WORD_W-1:0] read_data,
	input  logic                     cfg_wr_en,
	input  logic [COUNT_W-1:0]       cfg_wr_data
);

	pair_cmd_t  cmd;
	pair_stat_t stat;

	pair_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pair_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.func        (func),
		.position    (position),
		.data_word   (data_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.entry_count (entry_count),
		.read_data   (read_data)
	);

endmodule

// File: rtl/pair_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_datapath
// Entry memory, count and capacity registers, operation checks, shift pointer
// and the output register of the positional store.
// ----------------------------------------------------------------------------
module pair_datapath import pair_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pair_cmd_t                cmd,
	output pair_stat_t               stat,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [POS_W-1:0]  position,
	input  logic signed [WORD_W-1:0] data_word,
	input  logic                     cfg_wr_en,
	input  logic [COUNT_W-1:0]       cfg_wr_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [STAT_W-1:0]        status,
	output logic [COUNT_W-1:0]       entry_count,
	output logic signed [WORD_W-1:0] read_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CNT_LIM = (DEPTH < (1 << COUNT_W) - 1) ? DEPTH : (1 << COUNT_W) - 1;
	localparam logic [COUNT_W-1:0] DEPTH_LIM = COUNT_W'(CNT_LIM);

	logic [WORD_W-1:0]  mem [DEPTH];
	logic [WORD_W-1:0]  rdata_s1;

	logic [FUNC_W-1:0]  func_q;
	logic [POS_W-1:0]   pos_q;
	logic [WORD_W-1:0]  word_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] cap_q;
	logic [COUNT_W-1:0] ptr_q;
	logic [COUNT_W-1:0] at_q;
	logic [STAT_W-1:0]  st_q;

	logic               out_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [COUNT_W-1:0] entry_count_q;
	logic [WORD_W-1:0]  read_data_q;

	logic               pos_neg;
	logic [POS_W-2:0]   pos_mag;
	logic [POS_W-2:0]   cnt_ext;
	logic               in_range;
	logic               full;
	logic [COUNT_W-1:0] at_next;
	logic [STAT_W-1:0]  st_next;
	logic               is_insert;
	logic [COUNT_W-1:0] src_idx;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [WORD_W-1:0]  wdata;
	logic               re;
	logic [AW-1:0]      raddr;

	// operation checks against the registered transaction
	assign pos_neg   = pos_q[POS_W-1];
	assign pos_mag   = pos_q[POS_W-2:0];
	assign cnt_ext   = {{(POS_W-1-COUNT_W){1'b0}}, count_q};
	assign in_range  = !pos_neg && (pos_mag < cnt_ext);
	assign full      = (count_q >= cap_q) || (count_q >= DEPTH_LIM);
	assign at_next   = (pos_mag > cnt_ext) ? count_q : pos_q[COUNT_W-1:0];
	assign is_insert = (func_q == FUNC_INSERT);

	always_comb begin
		case (func_q)
			FUNC_INSERT: st_next = full ? STAT_FULL : (pos_neg ? STAT_BAD_INDEX : STAT_OK);
			FUNC_REMOVE: st_next = (count_q == '0) ? STAT_EMPTY :
			                       (in_range ? STAT_OK : STAT_BAD_INDEX);
			FUNC_READ:   st_next = in_range ? STAT_OK : STAT_BAD_INDEX;
			default:     st_next = STAT_BAD_INDEX;
		endcase
	end

	// insert moves entries up from the top, remove moves them down from the hole
	assign src_idx = is_insert ? (ptr_q - 1'b1) : (ptr_q + 1'b1);

	assign stat.op_ok     = (st_next == STAT_OK);
	assign stat.is_insert = is_insert;
	assign stat.is_read   = (func_q == FUNC_READ);
	assign stat.ptr_done  = is_insert ? !(ptr_q > at_q)
	                                  : !(({1'b0, ptr_q} + 1'b1) < {1'b0, count_q});
	assign stat.out_busy  = out_valid_q && out_stall;

	assign we    = cmd.shift_wr || cmd.write_word;
	assign waddr = cmd.write_word ? AW'(at_q) : AW'(ptr_q);
	assign wdata = cmd.write_word ? word_q : rdata_s1;
	assign re    = cmd.shift_rd || cmd.read_issue;
	assign raddr = cmd.read_issue ? AW'(pos_q[COUNT_W-1:0]) : AW'(src_idx);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			func_q <= func;
			pos_q  <= position;
			word_q <= data_word;
		end
		if (cmd.decode) begin
			st_q  <= st_next;
			at_q  <= at_next;
			ptr_q <= is_insert ? count_q : pos_q[COUNT_W-1:0];
		end else if (cmd.shift_wr) begin
			ptr_q <= is_insert ? (ptr_q - 1'b1) : (ptr_q + 1'b1);
		end
		if (cmd.result_load) begin
			status_q      <= st_q;
			entry_count_q <= count_q;
			read_data_q   <= (func_q == FUNC_READ && st_q == STAT_OK) ? rdata_s1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.count_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.count_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign read_data   = read_data_q;

	// count moves by one step at most
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == COUNT_W'($past(count_q) + 1'b1)) ||
			(count_q == COUNT_W'($past(count_q) - 1'b1)))
		else $error("count jumped by more than one");

	// a new result never overwrites one still held by the stall
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	// the final insert write always grows the count
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_word |=> count_q == COUNT_W'($past(count_q) + 1'b1))
		else $error("insert write without count increment");

	a_no_inc_dec: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.count_inc && cmd.count_dec))
		else $error("count increment and decrement together");

endmodule

// File: rtl/pair_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_ctrl
// Sequencer for the positional store: decodes a transaction, steps the entry
// shift of an insert or remove one read and one write at a time, then hands off the result.
// ----------------------------------------------------------------------------
module pair_ctrl import pair_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  pair_stat_t stat,
	output pair_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_DECODE    = 3'd1;
	localparam logic [2:0] S_SHIFT_RD  = 3'd2;
	localparam logic [2:0] S_SHIFT_WR  = 3'd3;
	localparam logic [2:0] S_WRITE     = 3'd4;
	localparam logic [2:0] S_READ_WAIT = 3'd5;
	localparam logic [2:0] S_RESP      = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_next;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_op = 1'b1;
					state_next  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (!stat.op_ok) begin
					state_next = S_RESP;
				end else if (stat.is_read) begin
					cmd.read_issue = 1'b1;
					state_next     = S_READ_WAIT;
				end else begin
					state_next = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				if (!stat.ptr_done) begin
					cmd.shift_rd = 1'b1;
					state_next   = S_SHIFT_WR;
				end else if (stat.is_insert) begin
					state_next = S_WRITE;
				end else begin
					cmd.count_dec = 1'b1;
					state_next    = S_RESP;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_next   = S_SHIFT_RD;
			end
			S_WRITE: begin
				cmd.write_word = 1'b1;
				cmd.count_inc  = 1'b1;
				state_next     = S_RESP;
			end
			S_READ_WAIT: begin
				state_next = S_RESP;
			end
			S_RESP: begin
				if (!stat.out_busy) begin
					cmd.result_load = 1'b1;
					state_next      = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// shift steps alternate read then write
	a_rd_then_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_rd |=> cmd.shift_wr)
		else $error("shift read not followed by its write");

	// an accepted transaction passes through its decode state before its result
	a_accept_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_op |=> !cmd.result_load)
		else $error("result issued in the cycle after accept");

	a_decode_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_op |=> cmd.decode)
		else $error("accepted transaction not decoded");

endmodule

// File: tb/sv/positional_array_insert_remove_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_insert_remove_core_test
// Self-checking bench for the positional store: insert, remove and read at
// signed positions under several capacity limits. A shadow copy of the store
// predicts results, and directed rows may carry their own expected outcomes. Random
// gaps and stalls are applied on both sides, and one long output stall backs the core up.
// ----------------------------------------------------------------------------
module positional_array_insert_remove_core_test;
	import pair_pkg::*;

	localparam int DEPTH       = 256;
	localparam int HALF_PERIOD = 2;
	localparam int LIMIT       = 2_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 600;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic [COUNT_W-1:0]       count;
		logic signed [WORD_W-1:0] data;
	} outcome_t;

	// one row is either a capacity write or a transaction to send
	typedef struct packed {
		logic                     cfg;
		logic [COUNT_W-1:0]       cap;
		logic [FUNC_W-1:0]        f;
		logic signed [POS_W-1:0]  p;
		logic signed [WORD_W-1:0] w;
		logic                     typed;
		outcome_t                 want;
	} plan_row_t;

	localparam int DIRECTED_ROWS = 28;

	plan_row_t directed_plan [DIRECTED_ROWS] = '{
		'{1'b0, 9'd0, FUNC_READ,   16'sd0,     32'sd0,        1'b1,
			'{STAT_BAD_INDEX, 9'd0, 32'sd0}},
		'{1'b0, 9'd0, FUNC_REMOVE, 16'sd0,     32'sd0,        1'b1,
			'{STAT_EMPTY, 9'd0, 32'sd0}},
		'{1'b0, 9'd0, FUNC_UNUSED, 16'sd0,     32'sd0,        1'b1,
			'{STAT_BAD_INDEX, 9'd0, 32'sd0}},
		'{1'b0, 9'd0, FUNC_INSERT, -16'sd1,    32'sd5,        1'b1,
			'{STAT_BAD_INDEX, 9'd0, 32'sd0}},
		'{1'b0, 9'd0, FUNC_INSERT, 16'sh8000,  32'sd5,        1'b1,
			'{STAT_BAD_INDEX, 9'd0, 32'sd0}},
		'{1'b0, 9'd0, FUNC_INSERT, 16'sd0,     32'h7FFFFFFF,  1'b1,
			'{STAT_OK, 9'd1, 32'sd0}},
		// far beyond the end lands at the end
		'{1'b0, 9'd0, FUNC_INSERT, 16'sd32767, 32'h80000000,  1'b1,
			'{STAT_OK, 9'd2, 32'sd0}},
		'{1'b0, 9'd0, FUNC_INSERT, 16'sd1,     32'sd0,        1'b1,
			'{STAT_OK, 9'd3, 32'sd0}},
		'{1'b0, 9'd0, FUNC_INSERT, 16'sd0,     32'hFFFFFFFF,  1'b1,
			'{STAT_OK, 9'd4, 32'sd0}},
		'{1'b0, 9'd0, FUNC_READ,   16'sd0,     32'sd0,        1'b0, '0},
		'{1'b0, 9'd0, FUNC_READ,   16'sd3,     32'sd0,        1'b0, '0},
		'{1'b0, 9'd0, FUNC_READ,   16'sd4,     32'sd0,        1'b1,
			'{STAT_BAD_INDEX, 9'd4, 32'sd0}},
		// index equal to count is already out of range for remove
		'{1'b0, 9'd0, FUNC_REMOVE, 16'sd4,     32'sd0,        1'b1,
			'{STAT_BAD_INDEX, 9'd4, 32'sd0}},
		'{1'b0, 9'd0, FUNC_REMOVE, 16'sh8000,  32'sd0,        1'b1,
			'{STAT_BAD_INDEX, 9'd4, 32'sd0}},
		'{1'b0, 9'd0, FUNC_REMOVE, 16'sd1,     32'sd0,        1'b0, '0},
		'{1'b0, 9'd0, FUNC_UNUSED, 16'sd1,     32'sd5,        1'b1,
			'{STAT_BAD_INDEX, 9'd3, 32'sd0}},
		'{1'b0, 9'd0, FUNC_REMOVE, 16'sd2,     32'sd0,        1'b0, '0},
		'{1'b0, 9'd0, FUNC_REMOVE, 16'sd0,     32'sd0,        1'b0, '0},
		'{1'b0, 9'd0, FUNC_REMOVE, 16'sd0,     32'sd0,        1'b0, '0},
		'{1'b0, 9'd0, FUNC_REMOVE, 16'sd0,     32'sd0,        1'b1,
			'{STAT_EMPTY, 9'd0, 32'sd0}},
		'{1'b1, 9'd0, FUNC_INSERT, 16'sd0,     32'sd0,        1'b0, '0},
		// full wins over a negative index
		'{1'b0, 9'd0, FUNC_INSERT, -16'sd1,    32'sd7,        1'b1,
			'{STAT_FULL, 9'd0, 32'sd0}},
		'{1'b1, 9'd1, FUNC_INSERT, 16'sd0,     32'sd0,        1'b0, '0},
		'{1'b0, 9'd0, FUNC_INSERT, -16'sd1,    32'sd7,        1'b1,
			'{STAT_BAD_INDEX, 9'd0, 32'sd0}},
		'{1'b0, 9'd0, FUNC_INSERT, 16'sd32767, 32'h55AA55AA,  1'b1,
			'{STAT_OK, 9'd1, 32'sd0}},
		'{1'b0, 9'd0, FUNC_INSERT, 16'sd0,     32'sd9,        1'b1,
			'{STAT_FULL, 9'd1, 32'sd0}},
		'{1'b0, 9'd0, FUNC_READ,   16'sd0,     32'sd0,        1'b0, '0},
		'{1'b0, 9'd0, FUNC_REMOVE, 16'sd0,     32'sd0,        1'b0, '0}
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [FUNC_W-1:0]        func;
	logic signed [POS_W-1:0]  position;
	logic signed [WORD_W-1:0] data_word;
	logic                     out_valid;
	logic                     out_stall;
	logic [STAT_W-1:0]        status;
	logic [COUNT_W-1:0]       entry_count;
	logic signed [WORD_W-1:0] read_data;
	logic                     cfg_wr_en;
	logic [COUNT_W-1:0]       cfg_wr_data;

	// shadow copy of the store
	logic signed [WORD_W-1:0] shadow_words [DEPTH];
	int                       shadow_count;
	logic [COUNT_W-1:0]       shadow_cap;

	outcome_t pending_outcomes [$];

	bit gaps_on = 1'b1;
	bit hold_req = 1'b0;
	int errors = 0;
	int ops_sent = 0;
	int results_seen = 0;
	int caps_written = 0;
	int peak_fill = 0;
	int cycle_count = 0;
	int status_hits [4] = '{0, 0, 0, 0};

	positional_array_insert_remove_core #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.position   (position),
		.data_word  (data_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.entry_count(entry_count),
		.read_data  (read_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_outcomes.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// applies one operation to the shadow store and returns its outcome
	function automatic outcome_t store_apply(input logic [FUNC_W-1:0] f,
			input logic signed [POS_W-1:0] p, input logic signed [WORD_W-1:0] w);
		outcome_t r;
		int pi;
		int room;
		int at;
		int i;
		r = '0;
		r.status = STAT_OK;
		pi = p;
		room = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
		case (f)
			FUNC_INSERT: begin
				if (shadow_count + 1 > room)
					r.status = STAT_FULL;
				else if (pi < 0)
					r.status = STAT_BAD_INDEX;
				else begin
					at = (pi > shadow_count) ? shadow_count : pi;
					for (i = shadow_count; i > at; i--)
						shadow_words[i] = shadow_words[i - 1];
					shadow_words[at] = w;
					shadow_count++;
				end
			end
			FUNC_REMOVE: begin
				if (shadow_count == 0)
					r.status = STAT_EMPTY;
				else if (pi < 0 || pi >= shadow_count)
					r.status = STAT_BAD_INDEX;
				else begin
					for (i = pi; i + 1 < shadow_count; i++)
						shadow_words[i] = shadow_words[i + 1];
					shadow_count--;
				end
			end
			FUNC_READ: begin
				if (pi < 0 || pi >= shadow_count)
					r.status = STAT_BAD_INDEX;
				else
					r.data = shadow_words[pi];
			end
			default: r.status = STAT_BAD_INDEX;
		endcase
		r.count = shadow_count[COUNT_W-1:0];
		return r;
	endfunction

	task automatic issue_op(input logic [FUNC_W-1:0] f, input logic signed [POS_W-1:0] p,
			input logic signed [WORD_W-1:0] w, input bit typed, input outcome_t typed_out);
		int gap;
		outcome_t model_out;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= f;
		position  <= p;
		data_word <= w;
		do @(posedge clk); while (in_stall);
		model_out = store_apply(f, p, w);
		pending_outcomes.push_back(typed ? typed_out : model_out);
		ops_sent++;
		if (shadow_count > peak_fill)
			peak_fill = shadow_count;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input logic [COUNT_W-1:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_cap = v;
		caps_written++;
	endtask

	// random mix; positions mostly near the live range, some negative or wild
	task automatic run_mixed(input int n, input int insert_pct);
		int roll;
		int k;
		int neg;
		logic [FUNC_W-1:0] f;
		logic signed [POS_W-1:0] p;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < insert_pct)
				f = FUNC_INSERT;
			else if (roll < insert_pct + (100 - insert_pct) / 2)
				f = FUNC_REMOVE;
			else if (roll < 97)
				f = FUNC_READ;
			else
				f = FUNC_UNUSED;
			k = $urandom_range(0, 9);
			if (k < 7)
				p = POS_W'($urandom_range(0, shadow_count + 1));
			else if (k == 7)
				p = POS_W'(shadow_count);
			else if (k == 8) begin
				neg = $urandom_range(1, 32768);
				p = POS_W'(-neg);
			end else
				p = POS_W'($urandom());
			issue_op(f, p, $urandom(), 1'b0, '0);
		end
	endtask

	initial begin : result_side
		outcome_t want;
		outcome_t got;
		int rx_wait;
		int hold_left;
		rx_wait = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = '{status, entry_count, read_data};
				results_seen++;
				if (got.status !== 2'bxx && !$isunknown(got.status))
					status_hits[got.status]++;
				if (pending_outcomes.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction: status %0d count %0d data %0d",
						$time, got.status, got.count, got.data);
				end else begin
					want = pending_outcomes.pop_front();
					if (got.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d, got %0d", $time,
							want.status, got.status);
					end
					if (got.count !== want.count) begin
						errors++;
						$display("%0t: entry_count expected %0d, got %0d", $time,
							want.count, got.count);
					end
					if (got.data !== want.data) begin
						errors++;
						$display("%0t: read_data expected %0d, got %0d", $time,
							want.data, got.data);
					end
				end
				rx_wait = gaps_on ? $urandom_range(0, 4) : 0;
			end else if (rx_wait > 0 && out_valid)
				rx_wait--;
			if (hold_left > 0)
				hold_left--;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			out_stall <= (rx_wait != 0) || (hold_left != 0);
		end
	end

	initial begin : stimulus
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		func        <= FUNC_INSERT;
		position    <= '0;
		data_word   <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		shadow_count = 0;
		shadow_cap = CAP_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].cfg)
				set_capacity(directed_plan[i].cap);
			else
				issue_op(directed_plan[i].f, directed_plan[i].p, directed_plan[i].w,
					directed_plan[i].typed, directed_plan[i].want);
		end

		set_capacity(9'd3);
		run_mixed(60, 50);
		gaps_on = 1'b0;
		set_capacity(9'd12);
		run_mixed(60, 55);
		gaps_on = 1'b1;
		set_capacity(COUNT_W'($urandom_range(1, 16)));
		run_mixed(60, 50);
		// above the depth, acts as the depth
		set_capacity(9'd300);
		run_mixed(60, 45);

		// fill to the brim, then two inserts that must bounce off as full
		set_capacity(CAP_RESET);
		repeat (DEPTH - shadow_count + 2)
			issue_op(FUNC_INSERT, POS_W'($urandom_range(0, shadow_count)), $urandom(),
				1'b0, '0);

		// long output stall while the sender keeps pushing
		set_capacity(9'd511);
		hold_req = 1'b1;
		run_mixed(30, 40);
		set_capacity(9'd0);
		run_mixed(30, 20);
		set_capacity(COUNT_W'($urandom_range(0, 511)));
		run_mixed(40, 50);

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d sent, %0d checked, %0d capacity writes, peak fill %0d of %0d",
			ops_sent, results_seen, caps_written, peak_fill, DEPTH);
		$display("status mix: ok %0d, bad index %0d, full %0d, empty %0d; %0d mismatches",
			status_hits[STAT_OK], status_hits[STAT_BAD_INDEX], status_hits[STAT_FULL],
			status_hits[STAT_EMPTY], errors);
		if (errors == 0 && pending_outcomes.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/pair_pkg.sv
rtl/pair_datapath.sv
rtl/pair_ctrl.sv
rtl/positional_array_insert_remove_core.sv
tb/sv/positional_array_insert_remove_core_test.sv
